// File: rtl/demstep_pkg.sv
// shared types, register indexes and saturation helper for the damped euler motion step
// no dependencies
`timescale 1ns / 1ps

package demstep_pkg;

  // fixed field widths
  localparam int unsigned VecW   = 32;
  localparam int unsigned StepW  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  // packed beat widths, padded to whole bytes
  localparam int unsigned InDataW  = 152;  // 145 bits of fields
  localparam int unsigned OutDataW = 200;  // 193 bits of fields

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DRAG = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_THR  = 1'b1;

  localparam logic [CfgW-1:0] DRAG_RESET = 16'd256;
  localparam logic [CfgW-1:0] THR_RESET  = 16'd1;

  // shared multiplier operand and product
  typedef logic signed [VecW:0]       op_t;
  typedef logic signed [2*VecW+1:0]   prod_t;
  typedef logic signed [VecW-1:0]     vec_t;

  // clamp a wide signed value to the 32 bit signed range
  function automatic vec_t sat32(prod_t v);
    vec_t r;
    if (v[2*VecW+1:VecW-1] == '0 || v[2*VecW+1:VecW-1] == '1) begin
      r = v[VecW-1:0];
    end else if (v[2*VecW+1]) begin
      r = {1'b1, {(VecW-1){1'b0}}};
    end else begin
      r = {1'b0, {(VecW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/demstep_mul.sv
// registered signed 33x33 multiplier shared by every step of the integrator
// depends on demstep_pkg
`timescale 1ns / 1ps

module demstep_mul (
  input  logic               clk_i,
  input  demstep_pkg::op_t   a_i,
  input  demstep_pkg::op_t   b_i,
  output demstep_pkg::prod_t p_o
);
  import demstep_pkg::*;

  prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= prod_t'(a_i) * prod_t'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/damped_euler_motion_step_unit.sv
// top level of the damped euler motion step: sequencer, state and stream ports
// depends on demstep_pkg and demstep_mul
`timescale 1ns / 1ps

// 2d body integrator, explicit euler with linear drag, signed q16.16 state.
// input beats on s_axis: tuser is the action (0 tick, 1 load), tdata the rest.
// result beats on m_axis: one per input beat, held until m_axis_tready.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 drag coefficient q8.8, 1 rest threshold); write only while idle.
// sequencing: a load beat, or a tick while the body rests, goes from accept
// to the done state, then into the output register once that is free.
// a moving tick runs 11 products through the one shared multiplier, one
// issue per cycle with the previous product consumed in the same cycle,
// then goes to the done state and on to the output register the same way.
// s_axis_tready is high only while idle; the block can accept the next beat
// while the previous result still waits, and stalls before writing a new
// result until the output register is free.
// reset: velocity and acceleration zero, body at rest, drag 1.0,
// threshold 1, no result pending.
module damped_euler_motion_step_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [demstep_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [demstep_pkg::CfgW-1:0]      cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // time_step[15:0], colliding[16], vel_x_in[48:17], vel_y_in[80:49],
  // acc_x_in[112:81], acc_y_in[144:113], zero pad above
  input  logic [demstep_pkg::InDataW-1:0]   s_axis_tdata,
  // action[0]
  input  logic                              s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // delta_x[31:0], delta_y[63:32], vel_x_out[95:64], vel_y_out[127:96],
  // acc_x_out[159:128], acc_y_out[191:160], at_rest[192], zero pad above
  output logic [demstep_pkg::OutDataW-1:0]  m_axis_tdata
);
  import demstep_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // sequencer steps: the product issued in a step is consumed in the next
  localparam logic [3:0] STEP_VX_DT = 4'd0;
  localparam logic [3:0] STEP_VY_DT = 4'd1;
  localparam logic [3:0] STEP_AX_DT = 4'd2;
  localparam logic [3:0] STEP_AY_DT = 4'd3;
  localparam logic [3:0] STEP_VX_DR = 4'd4;
  localparam logic [3:0] STEP_VY_DR = 4'd5;
  localparam logic [3:0] STEP_THR2  = 4'd6;
  localparam logic [3:0] STEP_VX2   = 4'd7;
  localparam logic [3:0] STEP_VY2   = 4'd8;
  localparam logic [3:0] STEP_AX2   = 4'd9;
  localparam logic [3:0] STEP_AY2   = 4'd10;
  localparam logic [3:0] STEP_LAST  = 4'd11;

  state_e state_q;
  logic [3:0] step_q;

  logic [CfgW-1:0] drag_q, thr_q;

  vec_t vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  logic resting_q;

  // per tick working registers
  logic [StepW-1:0] dt_q;
  logic             coll_q;
  vec_t             dx_q, dy_q;
  logic [VecW-1:0]  tt_q;
  logic [2*VecW-1:0] msum_q;
  logic             vz_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  // input field views
  logic             in_load;
  logic [StepW-1:0] in_dt;
  logic             in_coll;
  vec_t             in_vx, in_vy, in_ax, in_ay;

  assign in_load = s_axis_tuser;
  assign in_dt   = s_axis_tdata[15:0];
  assign in_coll = s_axis_tdata[16];
  assign in_vx   = s_axis_tdata[48:17];
  assign in_vy   = s_axis_tdata[80:49];
  assign in_ax   = s_axis_tdata[112:81];
  assign in_ay   = s_axis_tdata[144:113];

  // shared multiplier
  op_t   op_a, op_b;
  prod_t prod;
  op_t   dt_op, drag_neg;

  demstep_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign dt_op    = op_t'({{(VecW+1-StepW){1'b0}}, dt_q});
  assign drag_neg = -$signed({{(VecW+1-CfgW){1'b0}}, drag_q});

  always_comb begin
    unique case (step_q)
      STEP_VX_DT: begin op_a = op_t'(vel_x_q); op_b = dt_op; end
      STEP_VY_DT: begin op_a = op_t'(vel_y_q); op_b = dt_op; end
      STEP_AX_DT: begin op_a = op_t'(acc_x_q); op_b = dt_op; end
      STEP_AY_DT: begin op_a = op_t'(acc_y_q); op_b = dt_op; end
      STEP_VX_DR: begin op_a = op_t'(vel_x_q); op_b = drag_neg; end
      STEP_VY_DR: begin op_a = op_t'(vel_y_q); op_b = drag_neg; end
      STEP_THR2: begin
        op_a = op_t'({{(VecW+1-CfgW){1'b0}}, thr_q});
        op_b = op_t'({{(VecW+1-CfgW){1'b0}}, thr_q});
      end
      STEP_VX2:   begin op_a = op_t'(vel_x_q); op_b = op_t'(vel_x_q); end
      STEP_VY2:   begin op_a = op_t'(vel_y_q); op_b = op_t'(vel_y_q); end
      STEP_AX2:   begin op_a = op_t'(acc_x_q); op_b = op_t'(acc_x_q); end
      STEP_AY2:   begin op_a = op_t'(acc_y_q); op_b = op_t'(acc_y_q); end
      default:    begin op_a = '0; op_b = '0; end
    endcase
  end

  // product views: arithmetic shift right is floor division
  prod_t p_sh16, p_sh8;
  logic [2*VecW-1:0] sq, msum_next;
  logic below;

  assign p_sh16    = prod >>> 16;
  assign p_sh8     = prod >>> 8;
  assign sq        = prod[2*VecW-1:0];
  assign msum_next = msum_q + sq;
  assign below     = msum_next < {{VecW{1'b0}}, tt_q};

  assign s_axis_tready = (state_q == ST_IDLE);

  // output register takes a new result when empty or drained this cycle
  logic out_load;
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= DRAG_RESET;
      thr_q  <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DRAG: drag_q <= cfg_data_i;
        CFG_THR:  thr_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // body state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_VX_DT;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
      resting_q <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            dx_q   <= '0;
            dy_q   <= '0;
            dt_q   <= in_dt;
            coll_q <= in_coll;
            step_q <= STEP_VX_DT;
            if (in_load) begin
              vel_x_q   <= in_vx;
              vel_y_q   <= in_vy;
              acc_x_q   <= in_ax;
              acc_y_q   <= in_ay;
              resting_q <= (in_vx == '0) && (in_vy == '0) &&
                           (in_ax == '0) && (in_ay == '0);
              state_q   <= ST_DONE;
            end else if (resting_q) begin
              // resting body: tick changes nothing
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          step_q <= step_q + 4'd1;
          // consume the product issued in the previous step
          unique case (step_q)
            STEP_VY_DT: dx_q <= p_sh16[VecW-1:0];
            STEP_AX_DT: dy_q <= p_sh16[VecW-1:0];
            STEP_AY_DT: vel_x_q <= sat32(prod_t'(vel_x_q) + p_sh16);
            STEP_VX_DR: vel_y_q <= sat32(prod_t'(vel_y_q) + p_sh16);
            STEP_VY_DR: acc_x_q <= sat32(p_sh8);
            STEP_THR2:  acc_y_q <= sat32(p_sh8);
            STEP_VX2:   tt_q    <= prod[VecW-1:0];
            STEP_VY2:   msum_q  <= sq;
            STEP_AX2: begin
              // velocity magnitude test
              vz_q <= below;
              if (below) begin
                vel_x_q <= '0;
                vel_y_q <= '0;
              end
            end
            STEP_AY2:   msum_q  <= sq;
            STEP_LAST: begin
              // acceleration magnitude test, then settle rest flag
              if (below) begin
                acc_x_q <= '0;
                acc_y_q <= '0;
              end
              resting_q <= vz_q && below && !coll_q;
              state_q   <= ST_DONE;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {{(OutDataW - 6*VecW - 1){1'b0}}, resting_q,
                   acc_y_q, acc_x_q, vel_y_q, vel_x_q, dy_q, dx_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: rtl/demstep_chk.sv
// port level checks for the damped euler motion step, bound to the top level
// depends on demstep_pkg and damped_euler_motion_step_unit
`timescale 1ns / 1ps

module demstep_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [demstep_pkg::OutDataW-1:0]    m_axis_tdata
);
  import demstep_pkg::*;

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  // a result held back keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  // a result held back keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // one beat in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !s_axis_tready)
    else $error("input accepted while a beat is in work");

  // a load beat accepted with no result held back passes the done state into the output without stalling
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && s_axis_tuser && !(m_axis_tvalid && !m_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("load result late");

  // a body at rest has zero velocity and acceleration
  a_rest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[192] |-> m_axis_tdata[191:64] == '0)
    else $error("at rest with nonzero motion");

endmodule

bind damped_euler_motion_step_unit demstep_chk u_demstep_chk (.*);

// File: test/tb.sv
// self-checking bench for damped_euler_motion_step_unit: directed and random beats
// checked against an in-bench model of the damped euler body
// depends on demstep_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb;
  import demstep_pkg::*;

  // beat kinds carried on s_axis_tuser
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  // one input beat, packed into tdata/tuser by send_beat
  typedef struct packed {
    action_e          action;
    logic [StepW-1:0] time_step;
    logic             colliding;
    vec_t             vel_x;
    vec_t             vel_y;
    vec_t             acc_x;
    vec_t             acc_y;
  } motion_cmd_t;

  // one result beat
  typedef struct packed {
    vec_t delta_x;
    vec_t delta_y;
    vec_t vel_x;
    vec_t vel_y;
    vec_t acc_x;
    vec_t acc_y;
    logic at_rest;
  } motion_state_t;

  localparam longint VEC_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint VEC_MIN = 64'shFFFF_FFFF_8000_0000;

  // quiet time after the last result, enough to cover a moving tick in flight
  localparam int SETTLE_CYCLES = 16;
  // worst quiet stretch: the receiver hold-off plus the longest gap and a tick,
  // taken several times over
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BEATS   = 160;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // time_step, colliding, vel_x_in, vel_y_in, acc_x_in, acc_y_in, zero pad
  logic [InDataW-1:0]  s_axis_tdata;
  // action
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // delta_x, delta_y, vel_x_out, vel_y_out, acc_x_out, acc_y_out, at_rest, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  // model of the body and its registers
  vec_t      body_vx, body_vy, body_ax, body_ay;
  logic      body_rest;
  logic [CfgW-1:0] drag_q, thr_q;

  motion_state_t motion_q[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int gap_pct        = 30;   // chance of a gap before a beat
  int stall_pct      = 30;   // chance of a stall on the result side
  int hold_off_left  = 0;    // long receiver hold-off, counted down by the sink

  damped_euler_motion_step_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // body model
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint v);
    if (v > VEC_MAX) return VEC_MAX;
    if (v < VEC_MIN) return VEC_MIN;
    return v;
  endfunction

  // squared magnitude against squared threshold, exact in 64 unsigned bits
  function automatic logic is_negligible(input longint x, input longint y);
    logic [63:0] ux, uy, lim;
    ux  = (x < 0) ? -x : x;
    uy  = (y < 0) ? -y : y;
    lim = 64'(thr_q);
    return (ux * ux + uy * uy) < lim * lim;
  endfunction

  // apply one accepted beat to the body and return the result it must produce
  function automatic motion_state_t advance_body(input motion_cmd_t c);
    motion_state_t r;
    longint dt, drag, p, vx, vy, ax, ay;
    logic vz, az;
    r.delta_x = '0;
    r.delta_y = '0;
    dt   = longint'(c.time_step);
    drag = longint'(drag_q);
    if (c.action == ACT_LOAD) begin
      // a load ignores step and collision, rests only when all four are zero
      body_vx   = c.vel_x;
      body_vy   = c.vel_y;
      body_ax   = c.acc_x;
      body_ay   = c.acc_y;
      body_rest = (c.vel_x == 0) && (c.vel_y == 0) && (c.acc_x == 0) && (c.acc_y == 0);
    end else if (!body_rest) begin
      vx = longint'(body_vx);
      vy = longint'(body_vy);
      ax = longint'(body_ax);
      ay = longint'(body_ay);
      // translation from the old velocity, arithmetic shift floors
      p = (vx * dt) >>> 16;
      r.delta_x = p[31:0];
      p = (vy * dt) >>> 16;
      r.delta_y = p[31:0];
      vx = clamp32(vx + ((ax * dt) >>> 16));
      vy = clamp32(vy + ((ay * dt) >>> 16));
      // drag acts on the new velocity
      ax = clamp32((-vx * drag) >>> 8);
      ay = clamp32((-vy * drag) >>> 8);
      vz = is_negligible(vx, vy);
      az = is_negligible(ax, ay);
      if (vz) begin
        vx = 0;
        vy = 0;
      end
      if (az) begin
        ax = 0;
        ay = 0;
      end
      body_vx   = vx[31:0];
      body_vy   = vy[31:0];
      body_ax   = ax[31:0];
      body_ay   = ay[31:0];
      body_rest = vz && az && !c.colliding;
    end
    // a tick while at rest falls through and repeats the state
    r.vel_x   = body_vx;
    r.vel_y   = body_vy;
    r.acc_x   = body_ax;
    r.acc_y   = body_ay;
    r.at_rest = body_rest;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic motion_cmd_t make_cmd(input action_e act, input logic [StepW-1:0] dt,
                                           input logic coll, input vec_t vx, input vec_t vy,
                                           input vec_t ax, input vec_t ay);
    motion_cmd_t c;
    c.action    = act;
    c.time_step = dt;
    c.colliding = coll;
    c.vel_x     = vx;
    c.vel_y     = vy;
    c.acc_x     = ax;
    c.acc_y     = ay;
    return c;
  endfunction

  // mix of full range, small, extreme and mid-sized values
  function automatic vec_t rand_vec();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0: return r;
      1: return vec_t'($urandom_range(8191)) - 4096;
      2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0001;
          3: return 32'hFFFF_FFFF;
          default: return '0;
        endcase
      end
      3: return {{12{r[19]}}, r[19:0]};
      default: return {{4{r[27]}}, r[27:0]};
    endcase
  endfunction

  function automatic logic [StepW-1:0] rand_step();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(1, 255));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(2048, 8192));
    endcase
  endfunction

  function automatic motion_cmd_t rand_cmd(input action_e act);
    motion_cmd_t c;
    c = make_cmd(act, rand_step(), 1'($urandom_range(1)),
                 rand_vec(), rand_vec(), rand_vec(), rand_vec());
    // some loads put the body straight to rest
    if (act == ACT_LOAD && $urandom_range(15) == 0) begin
      c.vel_x = '0;
      c.vel_y = '0;
      c.acc_x = '0;
      c.acc_y = '0;
    end
    return c;
  endfunction

  // offer one beat, hold it until accepted, then record its expected result
  task automatic send_beat(input motion_cmd_t c);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.action;
    s_axis_tdata  = InDataW'({c.acc_y, c.acc_x, c.vel_y, c.vel_x, c.colliding, c.time_step});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    motion_q.push_back(advance_body(c));
  endtask

  // stop offering, let every result come back and the unit go quiet
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    if (idx == CFG_DRAG) begin
      drag_q = val;
    end else begin
      thr_q = val;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // body starts at rest: a tick changes nothing, an all-zero load keeps it resting
  task automatic test_reset_state();
    send_beat(make_cmd(ACT_TICK, 16'hFFFF, 1'b1, '1, '1, '1, '1));
    send_beat(make_cmd(ACT_LOAD, 16'hFFFF, 1'b1, '0, '0, '0, '0));
  endtask

  // saturation both ways, zero and unit steps, collision, floor of negatives
  task automatic test_motion_extremes();
    send_beat(make_cmd(ACT_LOAD, 16'h0000, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000));
    send_beat(make_cmd(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'h0000, 1'b0, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'h0001, 1'b1, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_LOAD, 16'h1234, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'h8000, 1'b0, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_LOAD, 16'h0000, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFD,
                       32'hFFFF_FFFF, 32'h0000_0003));
    send_beat(make_cmd(ACT_TICK, 16'h0001, 1'b0, '0, '0, '0, '0));
  endtask

  // drag and threshold at their extremes
  task automatic test_drag_and_threshold();
    wait_idle();
    // full drag saturates the new acceleration, a zero threshold never zeroes
    write_reg(CFG_DRAG, 16'hFFFF);
    write_reg(CFG_THR, 16'h0000);
    send_beat(make_cmd(ACT_LOAD, 16'h0000, 1'b0, 32'h7FFF_FFFF, 32'h8000_0001, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'h0001, 1'b0, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_LOAD, 16'h0000, 1'b0, '0, '0, 32'h0000_0001, '0));
    send_beat(make_cmd(ACT_TICK, 16'h7FFF, 1'b0, '0, '0, '0, '0));
    wait_idle();
    // no drag, widest threshold: collision holds off rest, then the body settles
    write_reg(CFG_DRAG, 16'h0000);
    write_reg(CFG_THR, 16'hFFFF);
    send_beat(make_cmd(ACT_LOAD, 16'h0000, 1'b0, 32'd100, -32'sd100, 32'd5, 32'd5));
    send_beat(make_cmd(ACT_TICK, 16'h4000, 1'b1, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'h4000, 1'b0, '0, '0, '0, '0));
    send_beat(make_cmd(ACT_TICK, 16'hFFFF, 1'b0, '0, '0, '0, '0));
    wait_idle();
    write_reg(CFG_DRAG, DRAG_RESET);
    write_reg(CFG_THR, THR_RESET);
  endtask

  // receiver holds off long enough for the unit to fill and stall its input
  task automatic test_backpressure();
    int i;
    wait_idle();
    gap_pct       = 0;
    hold_off_left = HOLD_CYCLES;
    send_beat(rand_cmd(ACT_LOAD));
    for (i = 0; i < 7; i++) send_beat(rand_cmd(ACT_TICK));
    gap_pct = 30;
  endtask

  // loads followed by runs of ticks, with some stray beats mixed in
  task automatic run_random(input int beats);
    int sent, n, i;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) < 8) begin
        send_beat(rand_cmd(ACT_LOAD));
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) send_beat(rand_cmd(ACT_TICK));
        sent += n + 1;
      end else begin
        send_beat(rand_cmd(action_e'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    int ph;
    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          // reset settings and no idling at all
          write_reg(CFG_DRAG, DRAG_RESET);
          write_reg(CFG_THR, THR_RESET);
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(CFG_DRAG, 16'h0000);
          write_reg(CFG_THR, 16'h0000);
          gap_pct   = 50;
          stall_pct = 50;
        end
        2: begin
          write_reg(CFG_DRAG, 16'hFFFF);
          write_reg(CFG_THR, 16'hFFFF);
          gap_pct   = $urandom_range(10, 40);
          stall_pct = $urandom_range(10, 40);
        end
        3: begin
          // moderate drag and thresholds that let bodies come to rest
          write_reg(CFG_DRAG, 16'($urandom_range(0, 512)));
          write_reg(CFG_THR, 16'($urandom_range(0, 4096)));
          gap_pct   = $urandom_range(0, 30);
          stall_pct = $urandom_range(0, 30);
        end
        default: begin
          write_reg(CFG_DRAG, 16'($urandom_range(65535)));
          write_reg(CFG_THR, 16'($urandom_range(65535)));
          gap_pct   = $urandom_range(10, 50);
          stall_pct = $urandom_range(10, 50);
        end
      endcase
      run_random(PHASE_BEATS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready with random stalls, or a long hold-off when one is requested
  initial begin : result_sink
    int stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        m_axis_tready = 1'b0;
        hold_off_left--;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(99) < stall_pct) stall = pick_gap();
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch %s: expected %h, got %h", fname, want, got);
      end
    end
  endtask

  // compare each result beat with the oldest expected one
  always @(posedge clk_i) begin : result_check
    motion_state_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.delta_x = m_axis_tdata[31:0];
      got.delta_y = m_axis_tdata[63:32];
      got.vel_x   = m_axis_tdata[95:64];
      got.vel_y   = m_axis_tdata[127:96];
      got.acc_x   = m_axis_tdata[159:128];
      got.acc_y   = m_axis_tdata[191:160];
      got.at_rest = m_axis_tdata[192];
      if (motion_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result beat with nothing expected");
      end else begin
        want = motion_q.pop_front();
        check_field("delta_x", want.delta_x, got.delta_x);
        check_field("delta_y", want.delta_y, got.delta_y);
        check_field("vel_x", want.vel_x, got.vel_x);
        check_field("vel_y", want.vel_y, got.vel_y);
        check_field("acc_x", want.acc_x, got.acc_x);
        check_field("acc_y", want.acc_y, got.acc_y);
        check_field("at_rest", 32'(want.at_rest), 32'(got.at_rest));
      end
    end
    // watchdog bookkeeping: any beat on either side counts as progress
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DRAG;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    drag_q        = DRAG_RESET;
    thr_q         = THR_RESET;
    body_vx       = '0;
    body_vy       = '0;
    body_ax       = '0;
    body_ay       = '0;
    body_rest     = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_motion_extremes();
    test_drag_and_threshold();
    test_backpressure();
    test_random_phases();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/demstep_pkg.sv
rtl/demstep_mul.sv
rtl/damped_euler_motion_step_unit.sv
rtl/demstep_chk.sv
test/tb.sv
